// File: src/hssg_pkg.sv
// hssg_pkg: shared types, constants and the 2^x fraction table
// for the hue-selective saturation gain pipeline; no dependencies
`timescale 1ns / 1ps

package hssg_pkg;

  // gain format: unsigned Q8.GAIN_FRAC_BITS
  localparam int GAIN_FRAC_BITS = 16;
  localparam int GAIN_W         = 8 + GAIN_FRAC_BITS;

  // hue distance arithmetic
  localparam int HUE_MOD  = 179;
  localparam int HUE_FOLD = 90;
  localparam int DB_SCALE = 179;

  // n = 179 * dB, signed
  localparam int N_W = 18;

  // log2(10) / 3580 scaled by 2^32
  localparam int LOG_COEF_W = 22;
  localparam logic [LOG_COEF_W-1:0] LOG_COEF = 22'd3985355;
  localparam int PROD_W = N_W + LOG_COEF_W + 1;

  // exponent split: integer part and 16 fraction bits
  localparam int FRAC_W = 16;
  localparam int IP_W   = PROD_W - 32;
  localparam int IP_MAX = 8;

  // mantissa of 2^f in Q30
  localparam int M_W     = 31;
  localparam int M_ONE_SH = 30;

  localparam int SAT_MAX = 255;

  typedef enum logic [1:0] {
    REG_KEEP_HUE  = 2'd0,
    REG_HUE_GAIN  = 2'd1,
    REG_BASE_GAIN = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0]        keep_hue;
    logic [7:0]        hue_gain;
    logic signed [7:0] base_gain;
  } cfg_t;

  typedef struct packed {
    logic [7:0] hue;
    logic [7:0] lightness;
    logic [7:0] saturation;
  } pix_t;

  // word carried through the 2^f multiply chain
  typedef struct packed {
    pix_t                   pix;
    logic                   ovf;
    logic signed [IP_W-1:0] ip;
    logic [FRAC_W-1:0]      f;
    logic [M_W-1:0]         m;
  } pw_t;

  // round(2^30 * 2^(2^-(k+1)))
  function automatic logic [M_W-1:0] pow2_frac(input logic [3:0] k);
    logic [M_W-1:0] t;
    case (k)
      4'd0:    t = 31'd1518500250;
      4'd1:    t = 31'd1276901417;
      4'd2:    t = 31'd1170923762;
      4'd3:    t = 31'd1121280436;
      4'd4:    t = 31'd1097253708;
      4'd5:    t = 31'd1085434106;
      4'd6:    t = 31'd1079572136;
      4'd7:    t = 31'd1076653033;
      4'd8:    t = 31'd1075196443;
      4'd9:    t = 31'd1074468887;
      4'd10:   t = 31'd1074105295;
      4'd11:   t = 31'd1073923544;
      4'd12:   t = 31'd1073832680;
      4'd13:   t = 31'd1073787251;
      4'd14:   t = 31'd1073764537;
      default: t = 31'd1073753181;
    endcase
    return t;
  endfunction

endpackage

// File: src/hssg_front.sv
// hssg_front: hue distance, dB numerator and log2 exponent, three stages
// depends on hssg_pkg
`timescale 1ns / 1ps

module hssg_front import hssg_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  cfg_t cfg,
  input  logic in_valid,
  output logic in_ready,
  input  pix_t in_pix,
  output logic out_valid,
  input  logic out_ready,
  output pw_t  out_word
);

  logic v1, v2, v3;
  logic rdy1, rdy2, rdy3;

  pix_t              pix1, pix2;
  logic signed [7:0] dist1;
  logic signed [N_W-1:0] n2;

  logic signed [9:0]     diff;
  logic signed [9:0]     wrap;
  logic signed [9:0]     fold;
  logic signed [N_W-1:0] bg_x;
  logic signed [N_W-1:0] hg_x;
  logic signed [N_W-1:0] d_x;
  logic signed [N_W-1:0] n_next;
  logic signed [PROD_W-1:0] prod;
  logic signed [IP_W-1:0]   ip_next;

  // handshake chain, a word moves when the next stage is free
  assign rdy3     = !v3 || out_ready;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;
  assign out_valid = v3;

  // stage 1: wrapped and folded hue distance
  always_comb begin
    diff = $signed({2'b00, cfg.keep_hue}) - $signed({2'b00, in_pix.hue});
    wrap = (diff < 0) ? diff + 10'(HUE_MOD) : diff;
    fold = (wrap >= 10'(HUE_FOLD)) ? 10'(HUE_MOD) - wrap : wrap;
  end

  // stage 2: n = 179 * base_gain - 2 * hue_gain * d
  always_comb begin
    bg_x   = N_W'(cfg.base_gain);
    hg_x   = $signed({{(N_W-8){1'b0}}, cfg.hue_gain});
    d_x    = N_W'(dist1);
    n_next = bg_x * N_W'(DB_SCALE) - ((hg_x * d_x) <<< 1);
  end

  // stage 3: exponent in Q.16, floor
  always_comb begin
    prod    = PROD_W'(n2) * $signed({1'b0, LOG_COEF});
    ip_next = prod[PROD_W-1:32];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      pix1  <= in_pix;
      dist1 <= fold[7:0];
    end
    if (rdy2 && v1) begin
      pix2 <= pix1;
      n2   <= n_next;
    end
    if (rdy3 && v2) begin
      out_word.pix <= pix2;
      out_word.ip  <= ip_next;
      out_word.ovf <= (ip_next >= IP_W'(IP_MAX));
      out_word.f   <= prod[31:16];
      out_word.m   <= M_W'(1) << M_ONE_SH;
    end
  end

endmodule

// File: src/hssg_pow2_step.sv
// hssg_pow2_step: one registered multiply of the 2^f mantissa chain
// depends on hssg_pkg (pow2_frac table)
`timescale 1ns / 1ps

module hssg_pow2_step import hssg_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic [3:0] step,
  input  logic       in_valid,
  output logic       in_ready,
  input  pw_t        in_word,
  output logic       out_valid,
  input  logic       out_ready,
  output pw_t        out_word
);

  logic                   valid;
  logic [3:0]             bit_pos;
  logic [2*M_W-1:0]       mprod;
  logic [M_W-1:0]         m_next;
  pw_t                    word_next;

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;

  // fraction bits are consumed from the top, weight 1/2 first
  always_comb begin
    bit_pos     = 4'(FRAC_W - 1) - step;
    mprod       = (2*M_W)'(in_word.m) * (2*M_W)'(pow2_frac(step));
    m_next      = in_word.f[bit_pos] ? mprod[M_ONE_SH +: M_W] : in_word.m;
    word_next   = in_word;
    word_next.m = m_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_word <= word_next;
    end
  end

endmodule

// File: src/hssg_back.sv
// hssg_back: mantissa shift to Q8.16 gain, saturation scaling and output register
// depends on hssg_pkg
`timescale 1ns / 1ps

module hssg_back import hssg_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  pw_t  in_word,
  output logic out_valid,
  input  logic out_ready,
  output pix_t out_pix
);

  localparam int SH_W     = M_W + 8;
  localparam int SP_W     = 8 + GAIN_W;
  localparam int SHR_BASE = M_ONE_SH - GAIN_FRAC_BITS;
  localparam logic [GAIN_W-1:0] GAIN_MAX = '1;

  logic v1, v2;
  logic rdy1, rdy2;

  pix_t              pix1;
  logic [GAIN_W-1:0] gain1;

  logic signed [9:0] shr;
  logic [9:0]        lsh;
  logic [SH_W-1:0]   wide;
  logic [GAIN_W-1:0] gain_next;
  logic [SP_W-1:0]   sp;
  logic [15:0]       scaled;
  logic [7:0]        sat_next;

  assign rdy2      = !v2 || out_ready;
  assign rdy1      = !v1 || rdy2;
  assign in_ready  = rdy1;
  assign out_valid = v2;

  // stage 1: 2^ip scaling of the mantissa, clamped to the gain range
  always_comb begin
    shr  = $signed(10'(SHR_BASE)) - 10'(in_word.ip);
    lsh  = 10'(-shr);
    wide = '0;
    if (shr < 0) begin
      wide = SH_W'(in_word.m) << lsh;
    end else if (shr < 10'sd31) begin
      wide = SH_W'(in_word.m >> shr[4:0]);
    end
    if (in_word.ovf || (wide > SH_W'(GAIN_MAX))) begin
      gain_next = GAIN_MAX;
    end else begin
      gain_next = wide[GAIN_W-1:0];
    end
  end

  // stage 2: saturation times gain, truncated and clipped
  always_comb begin
    sp       = SP_W'(pix1.saturation) * SP_W'(gain1);
    scaled   = sp[GAIN_FRAC_BITS +: 16];
    sat_next = (scaled > 16'(SAT_MAX)) ? 8'(SAT_MAX) : scaled[7:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      pix1  <= in_word.pix;
      gain1 <= gain_next;
    end
    if (rdy2 && v1) begin
      out_pix.hue        <= pix1.hue;
      out_pix.lightness  <= pix1.lightness;
      out_pix.saturation <= sat_next;
    end
  end

endmodule

// File: src/hue_selective_saturation_gain_core.sv
// hue_selective_saturation_gain_core: top level, config registers and pipeline
// depends on hssg_pkg, hssg_front, hssg_pow2_step, hssg_back
`timescale 1ns / 1ps

// Scales the saturation of an HLS pixel stream by a gain that depends on the
// hue distance to keep_hue: gain_dB = base_gain - hue_gain * dist / 89.5,
// applied as 10^(dB/20) in Q8.16. Hue and lightness pass through.
// Input channel: in_valid/in_ready with pixel_hue, pixel_lightness,
// pixel_saturation. Output channel: out_valid/out_ready with out_hue,
// out_lightness, out_saturation. One result word per input word, in order.
// The pipeline has three front stages (hue distance, dB numerator,
// log2 exponent), sixteen stages of the 2^f mantissa multiply chain, one
// stage of gain shift and clamp and one of saturation scaling into the
// output register. Throughput is one pixel per clock unless the receiver stalls.
// Every stage has its own valid bit; a stalled receiver holds the output
// register and the pipeline fills its empty stages before in_ready drops.
// Configuration: cfg_write, cfg_index (0 keep_hue, 1 hue_gain,
// 2 base_gain, 3 ignored) and cfg_data, to be written by the user only while
// the pipeline is empty; the block itself does not enforce this. Reset empties
// the pipeline and loads keep_hue 0, hue_gain 100, base_gain 0.

module hue_selective_saturation_gain_core import hssg_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] pixel_hue,
  input  logic [7:0] pixel_lightness,
  input  logic [7:0] pixel_saturation,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_hue,
  output logic [7:0] out_lightness,
  output logic [7:0] out_saturation
);

  localparam int STEPS = FRAC_W;

  cfg_t cfg;
  pix_t in_pix;
  pix_t out_pix;

  pw_t  chain_word  [0:STEPS];
  logic chain_valid [0:STEPS];
  logic chain_ready [0:STEPS];

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.keep_hue  <= 8'd0;
      cfg.hue_gain  <= 8'd100;
      cfg.base_gain <= 8'sd0;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_KEEP_HUE:  cfg.keep_hue  <= cfg_data;
        REG_HUE_GAIN:  cfg.hue_gain  <= cfg_data;
        REG_BASE_GAIN: cfg.base_gain <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  assign in_pix.hue        = pixel_hue;
  assign in_pix.lightness  = pixel_lightness;
  assign in_pix.saturation = pixel_saturation;

  hssg_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_pix    (in_pix),
    .out_valid (chain_valid[0]),
    .out_ready (chain_ready[0]),
    .out_word  (chain_word[0])
  );

  // 2^f mantissa chain, one fraction bit per stage
  for (genvar k = 0; k < STEPS; k++) begin : g_step
    hssg_pow2_step u_step (
      .clk       (clk),
      .rst       (rst),
      .step      (4'(k)),
      .in_valid  (chain_valid[k]),
      .in_ready  (chain_ready[k]),
      .in_word   (chain_word[k]),
      .out_valid (chain_valid[k+1]),
      .out_ready (chain_ready[k+1]),
      .out_word  (chain_word[k+1])
    );
  end

  hssg_back u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (chain_valid[STEPS]),
    .in_ready  (chain_ready[STEPS]),
    .in_word   (chain_word[STEPS]),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_pix   (out_pix)
  );

  assign out_hue        = out_pix.hue;
  assign out_lightness  = out_pix.lightness;
  assign out_saturation = out_pix.saturation;

endmodule

// File: tb/tb.sv
// tb: self-checking testbench for hue_selective_saturation_gain_core
// depends on hssg_pkg and the core; holds its own bit-exact gain predictor
`timescale 1ns / 1ps

module tb import hssg_pkg::*;;

  localparam int LATENCY       = 21;
  localparam int MAX_WAIT      = 18;
  localparam int QUIET_LIMIT   = 2000;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_PIXELS  = 110;
  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam longint LOG2_TEN_COEF = 64'sd3985355;
  localparam longint unsigned GAIN_CAP = (64'd1 << (8 + GAIN_FRAC_BITS)) - 64'd1;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [1:0] cfg_index = 2'd0;
  logic [7:0] cfg_data = 8'd0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [7:0] pixel_hue = 8'd0;
  logic [7:0] pixel_lightness = 8'd0;
  logic [7:0] pixel_saturation = 8'd0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [7:0] out_hue;
  logic [7:0] out_lightness;
  logic [7:0] out_saturation;

  // shadow of the config registers, reset values
  logic [7:0] shadow_target = 8'd0;
  logic [7:0] shadow_atten = 8'd100;
  logic signed [7:0] shadow_base = 8'sd0;

  pix_t expected_pixels[$];
  pix_t head_pixel;
  int mismatch_count = 0;
  int quiet_cycles = 0;
  bit no_idle = 1'b0;

  hue_selective_saturation_gain_core dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .pixel_hue(pixel_hue),
    .pixel_lightness(pixel_lightness),
    .pixel_saturation(pixel_saturation),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_hue(out_hue),
    .out_lightness(out_lightness),
    .out_saturation(out_saturation)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // 2^(2^-(k+1)) in Q30
  function automatic longint unsigned frac_factor(int k);
    case (k)
      0:       return 64'd1518500250;
      1:       return 64'd1276901417;
      2:       return 64'd1170923762;
      3:       return 64'd1121280436;
      4:       return 64'd1097253708;
      5:       return 64'd1085434106;
      6:       return 64'd1079572136;
      7:       return 64'd1076653033;
      8:       return 64'd1075196443;
      9:       return 64'd1074468887;
      10:      return 64'd1074105295;
      11:      return 64'd1073923544;
      12:      return 64'd1073832680;
      13:      return 64'd1073787251;
      14:      return 64'd1073764537;
      default: return 64'd1073753181;
    endcase
  endfunction

  // saturation after the hue-dependent gain, bit exact
  function automatic logic [7:0] predict_saturation(logic [7:0] hue, logic [7:0] sat);
    longint hue_dist;
    longint num;
    longint prod;
    longint ip;
    longint rsh;
    longint unsigned u;
    longint unsigned m;
    longint unsigned g;
    longint unsigned scaled;
    logic [15:0] f;
    // circular hue distance, folded at half a turn
    hue_dist = longint'(shadow_target) - longint'(hue);
    if (hue_dist < 0) hue_dist += 179;
    if (hue_dist >= 90) hue_dist = 179 - hue_dist;
    // dB times 179
    num = 179 * longint'(shadow_base) - 2 * longint'(shadow_atten) * hue_dist;
    // log2 of the linear gain in Q16, biased so the floor is a plain shift
    prod = num * LOG2_TEN_COEF;
    u = $unsigned(prod + (64'sd1 <<< 40)) >> 16;
    ip = $signed(u >> 16) - 256;
    f = u[15:0];
    if (ip >= 8) begin
      g = GAIN_CAP;
    end else begin
      m = 64'd1 << 30;
      for (int k = 0; k < 16; k++) begin
        if (f[15 - k]) m = (m * frac_factor(k)) >> 30;
      end
      // ip below 8 leaves only a right shift
      rsh = 30 - GAIN_FRAC_BITS - ip;
      m = (rsh >= 63) ? 64'd0 : (m >> rsh);
      g = (m > GAIN_CAP) ? GAIN_CAP : m;
    end
    scaled = ({56'd0, sat} * g) >> GAIN_FRAC_BITS;
    return (scaled > 64'd255) ? 8'd255 : scaled[7:0];
  endfunction

  function automatic int draw_wait();
    if (no_idle || $urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, MAX_WAIT);
  endfunction

  function automatic logic [7:0] pick_hue();
    if ($urandom_range(0, 19) == 0) return 8'($urandom_range(180, 255));
    return 8'($urandom_range(0, 179));
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ns mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(negedge clk);
    cfg_write = 1'b0;
    case (idx)
      REG_KEEP_HUE:  shadow_target = data;
      REG_HUE_GAIN:  shadow_atten = data;
      REG_BASE_GAIN: shadow_base = data;
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [7:0] target, input logic [7:0] atten, input int base);
    write_reg(REG_KEEP_HUE, target);
    write_reg(REG_HUE_GAIN, atten);
    write_reg(REG_BASE_GAIN, 8'(base));
  endtask

  // send one pixel word and queue its expected result
  task automatic send_pixel(input logic [7:0] hue, input logic [7:0] lig, input logic [7:0] sat);
    int gap;
    pix_t want;
    gap = draw_wait();
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    pixel_hue = hue;
    pixel_lightness = lig;
    pixel_saturation = sat;
    do @(posedge clk); while (!in_ready);
    want.hue = hue;
    want.lightness = lig;
    want.saturation = predict_saturation(hue, sat);
    expected_pixels.insert(expected_pixels.size(), want);
  endtask

  // stop sending and let the pipeline empty
  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  // reset register values: unity gain on target, full range of hue distance
  task automatic test_reset_defaults();
    send_pixel(8'd0, 8'd0, 8'd255);
    send_pixel(8'd0, 8'd255, 8'd128);
    send_pixel(8'd179, 8'd128, 8'd255);
    send_pixel(8'd89, 8'd1, 8'd200);
    send_pixel(8'd90, 8'd254, 8'd200);
    send_pixel(8'd45, 8'd85, 8'd170);
    send_pixel(8'd180, 8'd170, 8'd85);
    send_pixel(8'd255, 8'd0, 8'd255);
  endtask

  // gain clamp, underflow, ignored register, target outside the hue range
  task automatic test_gain_limits();
    wait_idle();
    set_config(8'd179, 8'd0, 127);
    send_pixel(8'd179, 8'd0, 8'd1);
    send_pixel(8'd0, 8'd255, 8'd0);
    send_pixel(8'd100, 8'd7, 8'd255);
    wait_idle();
    set_config(8'd0, 8'd255, -128);
    send_pixel(8'd90, 8'd3, 8'd255);
    send_pixel(8'd0, 8'd3, 8'd255);
    wait_idle();
    write_reg(REG_UNUSED, 8'h5a);
    send_pixel(8'd0, 8'd77, 8'd255);
    send_pixel(8'd20, 8'd78, 8'd255);
    wait_idle();
    set_config(8'd200, 8'd40, 6);
    send_pixel(8'd0, 8'd10, 8'd100);
    send_pixel(8'd30, 8'd11, 8'd200);
    send_pixel(8'd179, 8'd12, 8'd255);
    send_pixel(8'd255, 8'd13, 8'd90);
  endtask

  // random pixels over a series of register settings
  task automatic test_random_stream();
    int atten;
    int base;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      wait_idle();
      case (phase)
        0: set_config(8'd179, 8'd255, 127);
        1: set_config(8'd0, 8'd0, -128);
        2: set_config(8'd90, 8'd20, 0);
        default: begin
          atten = $urandom_range(0, 1) ? $urandom_range(0, 40) : $urandom_range(0, 255);
          base = $urandom_range(0, 1) ? int'($urandom_range(0, 40)) - 20
                                      : int'($urandom_range(0, 255)) - 128;
          set_config(8'($urandom_range(0, 179)), 8'(atten), base);
        end
      endcase
      for (int i = 0; i < PHASE_PIXELS; i++) begin
        if (i % 25 == 0) no_idle = ($urandom_range(0, 3) == 0);
        send_pixel(pick_hue(), 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      end
    end
    no_idle = 1'b0;
  endtask

  // receiver with random stalls
  initial begin
    int stall;
    forever begin
      @(negedge clk);
      stall = draw_wait();
      if (stall > 0) begin
        out_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!(out_valid && !rst));
    end
  end

  // compare each result word with the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_pixels.size() == 0) begin
        report_mismatch($sformatf("word with nothing pending: hue %0d sat %0d",
                                  out_hue, out_saturation));
      end else begin
        head_pixel = expected_pixels.pop_front();
        if (out_hue !== head_pixel.hue)
          report_mismatch($sformatf("out_hue got %0d expected %0d", out_hue, head_pixel.hue));
        if (out_lightness !== head_pixel.lightness)
          report_mismatch($sformatf("out_lightness got %0d expected %0d",
                                    out_lightness, head_pixel.lightness));
        if (out_saturation !== head_pixel.saturation)
          report_mismatch($sformatf("out_saturation got %0d expected %0d (hue %0d)",
                                    out_saturation, head_pixel.saturation, out_hue));
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // test sequence
  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_reset_defaults();
    test_gain_limits();
    test_random_stream();
    wait_idle();
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: hue_selective_saturation_gain_core.f
src/hssg_pkg.sv
src/hssg_front.sv
src/hssg_pow2_step.sv
src/hssg_back.sv
src/hue_selective_saturation_gain_core.sv
tb/tb.sv
